@@ rtl/ptd_pkg.sv @@
`timescale 1ns / 1ps

package ptd_pkg;

   localparam int TASKS       = 8;
   localparam int NUM_REGS    = 8;
   localparam int TICK_W      = 16;
   localparam int PERIOD_W    = 16;
   localparam int TASK_W      = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(TASKS - 1);

   // Status returned by the serial remainder unit.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LAUNCH = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage

@@ rtl/ptd_mod_unit.sv @@
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module ptd_mod_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ptd_pkg::TICK_W-1:0]       dividend,
   input  logic [ptd_pkg::PERIOD_W-1:0]     divisor,
   output ptd_pkg::mod_status_type          status
);

   localparam int CNT_W = $clog2(ptd_pkg::TICK_W);

   logic [ptd_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [ptd_pkg::TICK_W-1:0]   dvd_ff, dvd_in;
   logic [ptd_pkg::PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [ptd_pkg::PERIOD_W:0]   shifted;
   logic [ptd_pkg::PERIOD_W+1:0] diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[ptd_pkg::TICK_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // A negative difference means the shifted remainder stays as it is.
         if (!diff[ptd_pkg::PERIOD_W+1]) begin
            rem_in = diff[ptd_pkg::PERIOD_W-1:0];
         end else begin
            rem_in = shifted[ptd_pkg::PERIOD_W-1:0];
         end
         dvd_in = {dvd_ff[ptd_pkg::TICK_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ptd_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

@@ rtl/periodic_task_dispatcher_unit.sv @@
`timescale 1ns / 1ps

// A tick word is checked task by task: a disabled task (period zero) is skipped and an enabled
// task runs the shared serial remainder unit; then each due task is emitted in turn, lowest first.
// Throughput: one tick word per full check and emit pass; ready only while idle.
// Reset (synchronous, active high) clears the tick counter, all periods and the output valid.
module periodic_task_dispatcher_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptd_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] tick_pulse
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptd_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [2:0] task_index, [18:3] tick_value
   output logic                               rsp_tlast,   // last_due
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptd_pkg::PERIOD_W-1:0]       csr_data
);

   ptd_pkg::state_type            state_ff, state_in;
   logic [ptd_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [ptd_pkg::TASK_W-1:0]    task_ff, task_in;
   logic [ptd_pkg::TASKS-1:0]     due_ff, due_in;
   logic [ptd_pkg::PERIOD_W-1:0]  period_ff [ptd_pkg::NUM_REGS];

   logic                          out_valid_ff, out_valid_in;
   logic [ptd_pkg::TASK_W-1:0]    out_task_ff, out_task_in;
   logic [ptd_pkg::TICK_W-1:0]    out_tick_ff, out_tick_in;
   logic                          out_last_ff, out_last_in;

   logic                          mod_start;
   ptd_pkg::mod_status_type       mod_status;
   logic [ptd_pkg::PERIOD_W-1:0]  cur_period;
   logic                          out_free;
   logic [ptd_pkg::TASK_W-1:0]    low_idx;
   logic [ptd_pkg::TASKS-1:0]     due_rest;

   assign cur_period = period_ff[task_ff];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ptd_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   ptd_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_ff),
      .divisor  (cur_period),
      .status   (mod_status)
   );

   // Lowest pending due task.
   always_comb begin
      low_idx = '0;
      for (int i = ptd_pkg::TASKS - 1; i >= 0; i--) begin
         if (due_ff[i]) begin
            low_idx = ptd_pkg::TASK_W'(i);
         end
      end
      due_rest          = due_ff;
      due_rest[low_idx] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      task_in      = task_ff;
      due_in       = due_ff;
      mod_start    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_task_in  = out_task_ff;
      out_tick_in  = out_tick_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (req_tvalid && req_tdata[0]) begin
               tick_in  = tick_ff + 1'b1;
               task_in  = '0;
               due_in   = '0;
               state_in = ptd_pkg::ST_LAUNCH;
            end
         end
         ptd_pkg::ST_LAUNCH: begin
            if (cur_period == '0) begin
               if (task_ff == ptd_pkg::LAST_TASK) begin
                  state_in = ptd_pkg::ST_EMIT;
               end else begin
                  task_in = task_ff + 1'b1;
               end
            end else begin
               mod_start = 1'b1;
               state_in  = ptd_pkg::ST_WAIT;
            end
         end
         ptd_pkg::ST_WAIT: begin
            if (mod_status.done) begin
               due_in[task_ff] = mod_status.rem_zero;
               if (task_ff == ptd_pkg::LAST_TASK) begin
                  state_in = ptd_pkg::ST_EMIT;
               end else begin
                  task_in  = task_ff + 1'b1;
                  state_in = ptd_pkg::ST_LAUNCH;
               end
            end
         end
         ptd_pkg::ST_EMIT: begin
            if (due_ff == '0) begin
               state_in = ptd_pkg::ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_task_in  = low_idx;
               out_tick_in  = tick_ff;
               out_last_in  = (due_rest == '0);
               due_in       = due_rest;
               if (due_rest == '0) begin
                  state_in = ptd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptd_pkg::ST_IDLE;
         tick_ff      <= '0;
         task_ff      <= '0;
         due_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ptd_pkg::NUM_REGS; i++) begin
            period_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         task_ff      <= task_in;
         due_ff       <= due_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && (csr_index < ptd_pkg::CSR_INDEX_W'(ptd_pkg::NUM_REGS))) begin
            period_ff[csr_index[ptd_pkg::TASK_W-1:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_task_ff <= out_task_in;
      out_tick_ff <= out_tick_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ptd_pkg::RSP_DATA_W - ptd_pkg::TICK_W - ptd_pkg::TASK_W){1'b0}},
                        out_tick_ff, out_task_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
